### rtl/bcps_pkg.sv
// Package for the best-candidate point sampler.
// Holds the fixed field widths, the request mode codes and the sequencer state type.
// No dependencies.
`default_nettype none

package bcps_pkg;

    localparam int COORD_W = 16;   // width of the coordinate fields
    localparam int DIST_W  = 33;   // width of squared distances and the threshold
    localparam int PCNT_W  = 11;   // width of the reported point count

    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_CAND = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

### rtl/best_candidate_point_sampler.sv
// Best-candidate point sampler: seed points, candidate groups, nearest-point scan; uses bcps_pkg.
// A seed request goes straight into the store; a candidate runs the memory scan, one entry
// per cycle over the stored points, through the 3-stage distance pipeline, then a decide step.
// The last candidate of a group then reports from S_FINISH, which waits while a report is stalled.
// Throughput: one request at a time; in_stall is high until the request is done.
// Reset clears the count, held candidate, group flag, threshold and output valid, not the memory.
`default_nettype none

module best_candidate_point_sampler
    import bcps_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_wr_en,
    input  wire logic [DIST_W-1:0]   cfg_wr_data,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                mode,
    input  wire logic [COORD_W-1:0]  cand_x,
    input  wire logic [COORD_W-1:0]  cand_y,
    input  wire logic                group_end,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     accepted,
    output logic                     store_full,
    output logic [COORD_W-1:0]       best_x,
    output logic [COORD_W-1:0]       best_y,
    output logic [DIST_W-1:0]        best_dist_sq,
    output logic [PCNT_W-1:0]        point_count
);

    localparam int CW   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int PW   = 2 * CW;

    // Point memory, packed {y, x}
    logic [PW-1:0] mem [MAX_POINTS];

    state_t state_reg, state_next;

    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [CNTW-1:0]   rd_idx_reg, rd_idx_next;
    logic [DIST_W-1:0] thr_reg;
    logic              group_open_reg, group_open_next;
    logic [CW-1:0]     held_x_reg, held_x_next;
    logic [CW-1:0]     held_y_reg, held_y_next;
    logic [DIST_W-1:0] held_d_reg, held_d_next;
    logic [DIST_W-1:0] min_reg, min_next;
    logic              min_first_reg, min_first_next;

    logic [CW-1:0]     cur_x_reg, cur_y_reg;
    logic              last_reg;

    // Distance pipeline
    logic              p1_v_reg, p2_v_reg, p3_v_reg;
    logic [PW-1:0]     rdata_reg;
    logic [CW-1:0]     dx_reg, dy_reg;
    logic [PW-1:0]     sqx_reg, sqy_reg;
    logic [CW-1:0]     px, py;
    logic [DIST_W-1:0] dsum;

    logic              out_valid_reg, out_valid_next;
    logic              out_acc_reg, out_acc_next;
    logic              out_full_reg, out_full_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next;
    logic [COORD_W-1:0] out_y_reg, out_y_next;
    logic [DIST_W-1:0] out_d_reg, out_d_next;
    logic [PCNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic              issue;
    logic              has_room;
    logic              passed;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [PW-1:0]     mem_wdata;

    assign has_room = cnt_reg < CNTW'(MAX_POINTS);
    assign passed   = held_d_reg > thr_reg;
    assign px       = rdata_reg[CW-1:0];
    assign py       = rdata_reg[PW-1:CW];
    assign dsum     = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        group_open_next = group_open_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        held_d_next     = held_d_reg;
        min_next        = min_reg;
        min_first_next  = min_first_reg;
        out_valid_next  = out_valid_reg;
        out_acc_next    = out_acc_reg;
        out_full_next   = out_full_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_d_next      = out_d_reg;
        out_cnt_next    = out_cnt_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[AW-1:0];
        mem_wdata       = {cand_y[CW-1:0], cand_x[CW-1:0]};
        issue           = 1'b0;

        // drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // fold the distance leaving the pipeline into the running minimum
        if (p3_v_reg)
        begin
            if (min_first_reg || (dsum < min_reg))
            begin
                min_next = dsum;
            end
            min_first_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_SEED)
                    begin
                        // seeds go straight in; drop them when the store is full
                        if (has_room)
                        begin
                            mem_we   = 1'b1;
                            cnt_next = cnt_reg + CNTW'(1);
                        end
                    end
                    else
                    begin
                        rd_idx_next    = '0;
                        min_next       = '0;
                        min_first_next = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                issue = (rd_idx_reg != cnt_reg);
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNTW'(1);
                end
                else if (!p1_v_reg && !p2_v_reg && !p3_v_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // first candidate of a group is always held; ties keep the earlier one
                if (!group_open_reg || (min_reg > held_d_reg))
                begin
                    held_x_next = cur_x_reg;
                    held_y_next = cur_y_reg;
                    held_d_next = min_reg;
                end
                group_open_next = 1'b1;
                state_next      = last_reg ? S_FINISH : S_IDLE;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_acc_next  = passed && has_room;
                    out_full_next = passed && !has_room;
                    out_cnt_next  = PCNT_W'(cnt_reg);
                    if (passed && has_room)
                    begin
                        mem_we       = 1'b1;
                        mem_wdata    = {held_y_reg, held_x_reg};
                        cnt_next     = cnt_reg + CNTW'(1);
                        out_cnt_next = PCNT_W'(cnt_reg + CNTW'(1));
                    end
                    out_x_next      = COORD_W'(held_x_reg);
                    out_y_next      = COORD_W'(held_y_reg);
                    out_d_next      = held_d_reg;
                    out_valid_next  = 1'b1;
                    group_open_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rd_idx_reg     <= '0;
            thr_reg        <= '0;
            group_open_reg <= 1'b0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_d_reg     <= '0;
            min_reg        <= '0;
            min_first_reg  <= 1'b1;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            p3_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_idx_reg     <= rd_idx_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            group_open_reg <= group_open_next;
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            held_d_reg     <= held_d_next;
            min_reg        <= min_next;
            min_first_reg  <= min_first_next;
            p1_v_reg       <= issue;
            p2_v_reg       <= p1_v_reg;
            p3_v_reg       <= p2_v_reg;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            cur_x_reg <= cand_x[CW-1:0];
            cur_y_reg <= cand_y[CW-1:0];
            last_reg  <= group_end;
        end
        dx_reg  <= (px > cur_x_reg) ? (px - cur_x_reg) : (cur_x_reg - px);
        dy_reg  <= (py > cur_y_reg) ? (py - cur_y_reg) : (cur_y_reg - py);
        sqx_reg <= PW'(dx_reg) * PW'(dx_reg);
        sqy_reg <= PW'(dy_reg) * PW'(dy_reg);
        out_acc_reg  <= out_acc_next;
        out_full_reg <= out_full_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_d_reg    <= out_d_next;
        out_cnt_reg  <= out_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rdata_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_acc_reg;
    assign store_full   = out_full_reg;
    assign best_x       = out_x_reg;
    assign best_y       = out_y_reg;
    assign best_dist_sq = out_d_reg;
    assign point_count  = out_cnt_reg;

endmodule

`default_nettype wire
